[rtl/aes_block_cipher_defines.svh]
// Assertion macros for the block cipher checker
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH
// implication checked on every clock unless reset is low
`define AES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define AES_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/aes_pkg.sv]
//------------------------------------------------------------------------------
// aes_pkg
// Shared constants, tables and GF(2^8) helpers.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package aes_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 64;
	localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KSIZE = 3'd4;
	localparam logic [1:0] KSIZE_128 = 2'd0;
	localparam logic [1:0] KSIZE_192 = 2'd1;
	localparam logic [1:0] KSIZE_256 = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} block_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} block_out_t;

	localparam logic [7:0] FWD_BOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
	localparam logic [7:0] INV_BOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
	endfunction

	// forward column mix: 2 3 1 1
	function automatic logic [31:0] mix_fwd(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		mix_fwd = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
			a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
			a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
			xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
	endfunction

	// inverse mix as forward mix after the 4-5-4-5 preprocessing
	function automatic logic [31:0] mix_inv(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, u, v;
		a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
		u = xtime(xtime(a0 ^ a2));
		v = xtime(xtime(a1 ^ a3));
		mix_inv = mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
	endfunction
endpackage

[rtl/aes_stream_if.sv]
//------------------------------------------------------------------------------
// aes_stream_if
// Valid/ready channel carrying a generic payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
interface aes_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/aes_key_sched.sv]
//------------------------------------------------------------------------------
// aes_key_sched
// Key expansion, one word per cycle, into the round-key memory.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_key_sched #(
	parameter int unsigned ROUND_KEY_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [255:0] key,
	input  logic [1:0]  key_size,
	input  logic [5:0]  rd_addr,
	output logic [31:0] rd_data,
	output logic        busy
);
	logic [31:0] mem [ROUND_KEY_WORDS];
	logic [31:0] win_q [8];	// last nk words
	logic [5:0] idx_q;
	logic [3:0] ph_q;	// i mod nk
	logic [7:0] rcon_q;
	logic busy_q;
	logic [3:0] nk;
	logic [5:0] total;
	logic [2:0] last_w;
	logic [31:0] prev, t, wnew, wkeep;

	always_comb begin
		unique case (key_size)
			aes_pkg::KSIZE_128: begin nk = 4'd4; total = 6'd44; end
			aes_pkg::KSIZE_192: begin nk = 4'd6; total = 6'd52; end
			default: begin nk = 4'd8; total = 6'd60; end
		endcase
		last_w = 3'(nk - 4'd1);
		prev = win_q[last_w];
		if (ph_q == 4'd0)
			t = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rcon_q, 24'd0};
		else if (nk == 4'd8 && ph_q == 4'd4)
			t = aes_pkg::sub_word(prev);
		else
			t = prev;
		if (idx_q < 6'(nk))
			wnew = key[255 - 32*idx_q[2:0] -: 32];
		else
			wnew = t ^ win_q[0];
		// words past the store enter the window as zero
		wkeep = (32'(idx_q) < ROUND_KEY_WORDS) ? wnew : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			ph_q <= '0;
			rcon_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= '0;
			ph_q <= '0;
			rcon_q <= 8'h01;
		end else if (busy_q) begin
			idx_q <= idx_q + 6'd1;
			if (ph_q == nk - 4'd1) ph_q <= '0;
			else ph_q <= ph_q + 4'd1;
			if (ph_q == 4'd0 && idx_q >= 6'(nk)) rcon_q <= aes_pkg::xtime(rcon_q);
			if (idx_q == total - 6'd1) busy_q <= 1'b0;
		end
	end

	// shift window: oldest at 0, newest at nk-1
	always_ff @(posedge clk) begin
		if (busy_q) begin
			for (int k = 0; k < 8; k++) begin
				if (k == int'(last_w))
					win_q[k] <= wkeep;
				else if (k < 7)
					win_q[k] <= win_q[3'(k + 1)];
			end
			if (32'(idx_q) < ROUND_KEY_WORDS)
				mem[idx_q] <= wnew;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= (32'(rd_addr) < ROUND_KEY_WORDS) ? mem[rd_addr] : 32'd0;
	end

	assign busy = busy_q | start;
endmodule

[rtl/aes_round_unit.sv]
//------------------------------------------------------------------------------
// aes_round_unit
// Shared combinational round: forward or inverse sub/shift/mix plus key add; no mix in the last round.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_round_unit (
	input  logic [127:0] st,
	input  logic [127:0] rk,
	input  logic         inverse,
	input  logic         last,
	output logic [127:0] nxt
);
	logic [7:0] b [16];
	logic [7:0] s [16];
	logic [127:0] ss, sk;

	always_comb begin
		s = '{default: 8'h00};
		for (int i = 0; i < 16; i++)
			b[i] = st[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (inverse)
					s[r + 4*((c + r) % 4)] = aes_pkg::INV_BOX[b[r + 4*c]];
				else
					s[r + 4*c] = aes_pkg::FWD_BOX[b[r + 4*((c + r) % 4)]];
			end
		for (int i = 0; i < 16; i++)
			ss[127 - 8*i -: 8] = s[i];
		nxt = '0;
		sk = ss ^ rk;
		for (int c = 0; c < 4; c++) begin
			if (last)
				nxt[127 - 32*c -: 32] = sk[127 - 32*c -: 32];
			else if (inverse)
				nxt[127 - 32*c -: 32] = aes_pkg::mix_inv(sk[127 - 32*c -: 32]);
			else
				nxt[127 - 32*c -: 32] = aes_pkg::mix_fwd(ss[127 - 32*c -: 32]) ^ rk[127 - 32*c -: 32];
		end
	end
endmodule

[rtl/aes_block_cipher.sv]
//------------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 block cipher with an iterative round unit.
//------------------------------------------------------------------------------
// channel | dir | payload
// in_ch   | in  | mode, block_high, block_low
// out_ch  | out | result_high, result_low
// cfg     | in  | cfg_we, cfg_idx, cfg_data (key parts, key size)
// After a key write the first transaction first runs key expansion (one word
// per cycle into the schedule memory) and then hands over to the round loads.
// Each round key is read one word per cycle: four reads through the registered
// read port of the single key memory, then one round step, per round key. A new
// block is accepted only after the previous result has been taken.
// Reset clears control state; the key memory holds garbage until expanded.
// A finished result waits in the output register; input ready stays low meanwhile.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module aes_block_cipher #(
	parameter int unsigned ROUND_KEY_WORDS = 60
) (
	input  logic clk,
	input  logic arst_n,
	aes_stream_if.sink   in_ch,
	aes_stream_if.source out_ch,
	input  logic cfg_we,
	input  logic [aes_pkg::CfgIdxW-1:0] cfg_idx,
	input  logic [aes_pkg::CfgDataW-1:0] cfg_data
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001, S_EXP = 5'b00010, S_LOAD = 5'b00100,
		S_RUN = 5'b01000, S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [255:0] key_q;
	logic [1:0] ksize_q;
	logic sched_ok_q;
	logic mode_q;
	logic [127:0] st_q, rk_q;
	logic [3:0] rnd_q;	// rounds done
	logic [2:0] rdp_q;	// words issued, pipeline of read
	logic exp_start, exp_busy;
	logic [5:0] rd_addr;
	logic [31:0] rd_data;
	logic [3:0] nr, krnd;
	logic [127:0] rk_full, nxt_sel;
	logic first_add;

	assign nr = (ksize_q == aes_pkg::KSIZE_128) ? 4'd10 :
		(ksize_q == aes_pkg::KSIZE_192) ? 4'd12 : 4'd14;

	// config: any listed write invalidates the schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			ksize_q <= '0;
			sched_ok_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					aes_pkg::REG_KEY0: begin key_q[255:192] <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KEY1: begin key_q[191:128] <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KEY2: begin key_q[127:64] <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KEY3: begin key_q[63:0] <= cfg_data; sched_ok_q <= 1'b0; end
					aes_pkg::REG_KSIZE: begin ksize_q <= cfg_data[1:0]; sched_ok_q <= 1'b0; end
					default: ;
				endcase
			end
			if (state_q == S_EXP && !exp_busy) sched_ok_q <= 1'b1;
		end
	end

	// round key index: encrypt goes up, decrypt goes down
	assign krnd = mode_q ? (nr - rnd_q) : rnd_q;
	assign rd_addr = {krnd, 2'b00} + 6'(rdp_q[1:0]);

	aes_key_sched #(.ROUND_KEY_WORDS(ROUND_KEY_WORDS)) u_sched (
		.clk, .arst_n, .start(exp_start), .key(key_q), .key_size(ksize_q),
		.rd_addr, .rd_data, .busy(exp_busy)
	);

	// key words shift in from the bottom, word 0 ends up on top
	assign rk_full = {rk_q[95:0], rd_data};
	assign first_add = (rnd_q == 4'd0);

	// round unit consumes rk_q (complete after four loads)
	aes_round_unit u_round (
		.st(st_q), .rk(rk_q), .inverse(mode_q), .last(rnd_q == nr), .nxt(nxt_sel)
	);

	assign exp_start = (state_q == S_IDLE) && in_ch.valid && !sched_ok_q;
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rnd_q <= '0;
			rdp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_ch.valid) begin
					state_q <= sched_ok_q ? S_LOAD : S_EXP;
					rnd_q <= '0;
					rdp_q <= '0;
				end
				S_EXP: if (!exp_busy) state_q <= S_LOAD;
				S_LOAD: begin
					// rdp counts reads; read data arrives in the cycle after its address
					if (rdp_q == 3'd4) begin
						rdp_q <= '0;
						state_q <= S_RUN;
					end else begin
						rdp_q <= rdp_q + 3'd1;
					end
				end
				S_RUN: begin
					rnd_q <= rnd_q + 4'd1;
					state_q <= (rnd_q == nr) ? S_DONE : S_LOAD;
				end
				S_DONE: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_q <= in_ch.data.mode;
			st_q <= {in_ch.data.block_high, in_ch.data.block_low};
		end
		if (state_q == S_LOAD && rdp_q != 3'd0)
			rk_q <= rk_full;
		if (state_q == S_RUN) begin
			if (first_add) st_q <= st_q ^ rk_q;
			else st_q <= nxt_sel;
		end
	end

	assign out_ch.data.result_high = st_q[127:64];
	assign out_ch.data.result_low = st_q[63:0];
endmodule

[rtl/aes_block_cipher_checker.sv]
//------------------------------------------------------------------------------
// aes_block_cipher_checker
// Port-level checks on the cipher's handshakes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "aes_block_cipher_defines.svh"
module aes_block_cipher_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [127:0] out_data
);
	`AES_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready, "input open while result pending")
	`AES_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	`AES_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "second transaction taken")
endmodule

bind aes_block_cipher aes_block_cipher_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data({out_ch.data.result_high, out_ch.data.result_low})
);
